[rtl/rpn_stack_calculator_unit_assert.svh]
// assertion macros for the rpn stack calculator
`ifndef RPN_STACK_CALCULATOR_UNIT_ASSERT_SVH
`define RPN_STACK_CALCULATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RPN_ASSERT_IMPL(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define RPN_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define RPN_ASSERT_IMPL(lbl, clk, rst_n, prop)
`define RPN_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

[rtl/rpn_pkg.sv]
// ---------------------------------------------------------------------------
// rpn_pkg
// types and codes shared by the rpn stack calculator
// ---------------------------------------------------------------------------
package rpn_pkg;
    typedef enum logic [3:0] {
        CMD_PUSH = 4'd0, CMD_ADD = 4'd1, CMD_SUB = 4'd2, CMD_MUL = 4'd3,
        CMD_DIV = 4'd4, CMD_MOD = 4'd5, CMD_DUP = 4'd6, CMD_SWAP = 4'd7,
        CMD_CLEAR = 4'd8, CMD_PEEK = 4'd9, CMD_SETVAR = 4'd10,
        CMD_COPYVAR = 4'd11, CMD_PUSHVAR = 4'd12, CMD_NEXTSTACK = 4'd13,
        CMD_PUSHLAST = 4'd14, CMD_NOP = 4'd15
    } t_cmd;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_OVER  = 3'd1;
    localparam logic [2:0] ST_UNDER = 3'd2;
    localparam logic [2:0] ST_DIVZ  = 3'd3;
    localparam logic [2:0] ST_SAT   = 3'd4;

    typedef struct packed {
        logic [3:0]         cmd;
        logic signed [31:0] operand_value;
        logic [9:0]         var_index;
        logic [9:0]         var_source;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] top_value;
        logic [6:0]         depth;
        logic [2:0]         status;
    } t_out_word;

    // divider request and response
    typedef struct packed {
        logic        start;
        logic        neg;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
        logic [63:0] remainder;
    } t_div_rsp;
endpackage

[rtl/rpn_ram.sv]
// ---------------------------------------------------------------------------
// rpn_ram
// single port write, single port read ram with registered read
// ---------------------------------------------------------------------------
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/rpn_div.sv]
// ---------------------------------------------------------------------------
// rpn_div
// restoring divider on magnitudes, one quotient bit per cycle
// ---------------------------------------------------------------------------
module rpn_div
    import rpn_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic [63:0] r_quo;
    logic [63:0] r_rem;
    logic [63:0] r_dvs;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [64:0] w_trial;
    logic [63:0] w_rem_sh;

    assign w_rem_sh = {r_rem[62:0], r_quo[63]};
    assign w_trial  = {1'b0, w_rem_sh} - {1'b0, r_dvs};

    // one bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_req.start && r_busy && (r_cnt == 7'd1);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                if (w_trial[64]) begin
                    r_rem <= w_rem_sh;
                    r_quo <= {r_quo[62:0], 1'b0};
                end else begin
                    r_rem <= w_trial[63:0];
                    r_quo <= {r_quo[62:0], 1'b1};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;
endmodule

[rtl/rpn_stack_calculator_unit.sv]
// ---------------------------------------------------------------------------
// rpn_stack_calculator_unit
// reverse polish calculator on signed fixed point words, stack and
// variables held in synchronous rams
// ---------------------------------------------------------------------------
// channel  | ports                    | handshake
// command  | i_start, i_in, o_busy    | taken when i_start and !o_busy
// result   | o_valid, o_out           | one cycle strobe, no back pressure
//
// push, peek, stack, variable words: rd1, rd2, exec, toprd, out; swap adds topw
// add, sub and mul add mul and fin states: product register and write back
// div and mod wait in divw: the divider retires one bit a cycle over 64
// a zero divisor ends a div or mod at divw; too few entries go from exec to toprd
// after reset the variable ram is cleared, one entry a cycle, all VAR_COUNT entries
// the result strobe comes in the first cycle with busy low
module rpn_stack_calculator_unit
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int VAR_COUNT   = 1024,
    parameter int FRAC_BITS   = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_in_word  i_in,
    output logic      o_busy,
    output logic      o_valid,
    output t_out_word o_out
);
    localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int VAW = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
    localparam int DW  = $clog2(STACK_DEPTH + 1);
    localparam logic [DW-1:0] DMAX = DW'(STACK_DEPTH);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_RD1, S_RD2, S_EXEC, S_MUL, S_DIVW, S_FIN,
        S_TOPRD, S_TOPW, S_OUT
    } t_state;

    t_state      r_state;
    t_in_word    r_cmd;
    logic [DW-1:0] r_depth;
    logic [31:0] r_last;
    logic [31:0] r_a, r_b;
    logic [VAW:0] r_clr;
    logic [63:0] r_prod;
    logic [2:0]  r_st;
    logic        r_valid;
    t_out_word   r_out;
    logic        r_neg;

    // stack ram ports
    logic           s_we;
    logic [SAW-1:0] s_waddr, s_raddr;
    logic [31:0]    s_wdata, s_rdata;
    // variable ram ports
    logic           v_we;
    logic [VAW-1:0] v_waddr, v_raddr;
    logic [31:0]    v_wdata, v_rdata;
    logic           r_swap2;

    t_div_req w_dreq;
    t_div_rsp w_drsp;

    rpn_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata)
    );
    rpn_ram #(.WIDTH(32), .DEPTH(VAR_COUNT)) u_vars (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(v_wdata),
        .i_raddr(v_raddr), .o_rdata(v_rdata)
    );
    rpn_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    // helpers
    function automatic logic [31:0] sat64(input logic signed [64:0] v, output logic s);
        begin
            s = 1'b0;
            if (v > 65'sh7FFFFFFF) begin
                s = 1'b1;
                sat64 = 32'h7FFFFFFF;
            end else if (v < -65'sh80000000) begin
                s = 1'b1;
                sat64 = 32'h80000000;
            end else begin
                sat64 = v[31:0];
            end
        end
    endfunction

    logic [DW-1:0] w_dm1, w_dm2;
    logic          w_var_bad, w_src_bad;
    logic          w_bin;
    assign w_dm1 = r_depth - DW'(1);
    assign w_dm2 = r_depth - DW'(2);
    assign w_var_bad = (int'(r_cmd.var_index) >= VAR_COUNT);
    assign w_src_bad = (int'(r_cmd.var_source) >= VAR_COUNT);
    assign w_bin = r_cmd.cmd inside {CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD};

    // signed product of the two operands
    logic signed [63:0] w_prod;
    assign w_prod = $signed(r_a) * $signed(r_b);

    // magnitudes for the divider
    logic signed [63:0] w_a64, w_b64, w_ia, w_ib;
    logic [63:0] w_ua, w_ub;
    assign w_a64 = 64'(signed'(r_a));
    assign w_b64 = 64'(signed'(r_b));
    assign w_ia = (w_a64 < 0) ? -((-w_a64) >>> FRAC_BITS) : (w_a64 >>> FRAC_BITS);
    assign w_ib = (w_b64 < 0) ? -((-w_b64) >>> FRAC_BITS) : (w_b64 >>> FRAC_BITS);
    always_comb begin
        w_dreq = '0;
        if (r_cmd.cmd == CMD_DIV) begin
            w_ua = (w_a64 < 0) ? 64'(-w_a64) << FRAC_BITS : 64'(w_a64) << FRAC_BITS;
            w_ub = (w_b64 < 0) ? 64'(-w_b64) : 64'(w_b64);
        end else begin
            w_ua = (w_ia < 0) ? 64'(-w_ia) : 64'(w_ia);
            w_ub = (w_ib < 0) ? 64'(-w_ib) : 64'(w_ib);
        end
        w_dreq.dividend = w_ua;
        w_dreq.divisor  = w_ub;
        w_dreq.neg      = r_neg;
        w_dreq.start    = (r_state == S_MUL) &&
            ((r_cmd.cmd == CMD_DIV && r_b != 0) || (r_cmd.cmd == CMD_MOD && w_ib != 0));
    end

    // combinational result of the two-operand ops
    logic signed [64:0] w_res;
    logic [31:0] w_sat;
    logic        w_sflag;
    always_comb begin
        w_res = '0;
        case (r_cmd.cmd)
            CMD_ADD: w_res = 65'(signed'(r_a)) + 65'(signed'(r_b));
            CMD_SUB: w_res = 65'(signed'(r_a)) - 65'(signed'(r_b));
            CMD_MUL: w_res = 65'(signed'(r_prod)) >>> FRAC_BITS;
            CMD_DIV: w_res = r_neg ? -65'(w_drsp.quotient) : 65'(w_drsp.quotient);
            CMD_MOD: w_res = (r_neg ? -65'(w_drsp.remainder) : 65'(w_drsp.remainder))
                             <<< FRAC_BITS;
            default: w_res = '0;
        endcase
        w_sat = sat64(w_res, w_sflag);
    end

    // memory port control
    always_comb begin
        s_we = 1'b0; s_waddr = '0; s_wdata = '0;
        v_we = 1'b0; v_waddr = '0; v_wdata = '0;
        s_raddr = SAW'(w_dm1);
        v_raddr = (r_cmd.cmd == CMD_COPYVAR) ? VAW'(r_cmd.var_source) : VAW'(r_cmd.var_index);
        if (r_state == S_RD2) s_raddr = SAW'(w_dm2);
        if (r_state == S_CLR) begin
            v_we = 1'b1; v_waddr = VAW'(r_clr); v_wdata = '0;
        end
        if (r_state == S_EXEC) begin
            case (r_cmd.cmd)
                CMD_PUSH: begin
                    s_we = (r_depth < DMAX); s_waddr = SAW'(r_depth);
                    s_wdata = r_cmd.operand_value;
                end
                CMD_DUP: begin
                    s_we = (r_depth != 0) && (r_depth < DMAX);
                    s_waddr = SAW'(r_depth); s_wdata = r_b;
                end
                CMD_PUSHVAR: begin
                    s_we = !w_var_bad && (r_depth < DMAX);
                    s_waddr = SAW'(r_depth); s_wdata = v_rdata;
                end
                CMD_PUSHLAST: begin
                    s_we = (r_depth < DMAX); s_waddr = SAW'(r_depth); s_wdata = r_last;
                end
                CMD_SWAP: begin
                    s_we = (r_depth >= DW'(2)); s_waddr = SAW'(w_dm1); s_wdata = s_rdata;
                end
                CMD_SETVAR: begin
                    v_we = !w_var_bad; v_waddr = VAW'(r_cmd.var_index);
                    v_wdata = r_cmd.operand_value;
                end
                CMD_COPYVAR: begin
                    v_we = !w_var_bad && !w_src_bad; v_waddr = VAW'(r_cmd.var_index);
                    v_wdata = v_rdata;
                end
                default: ;
            endcase
        end
        if (r_state == S_FIN && r_st != ST_DIVZ) begin
            s_we = 1'b1; s_waddr = SAW'(w_dm2); s_wdata = w_sat;
        end
        if (r_swap2) begin
            s_we = 1'b1; s_waddr = SAW'(w_dm2); s_wdata = r_b;
        end
    end

    // sequencer and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_depth <= '0;
            r_last  <= '0;
            r_valid <= 1'b0;
            r_swap2 <= 1'b0;
        end else begin
            r_valid <= (r_state == S_OUT);
            r_swap2 <= (r_state == S_EXEC) && (r_cmd.cmd == CMD_SWAP) &&
                       (r_depth >= DW'(2));
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (VAW+1)'(VAR_COUNT - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (i_start) begin
                    r_cmd   <= i_in;
                    r_st    <= ST_OK;
                    r_state <= S_RD1;
                end
                S_RD1: r_state <= S_RD2;
                S_RD2: begin
                    r_b <= s_rdata;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_a <= s_rdata;
                    if (r_cmd.cmd == CMD_SWAP && r_depth >= DW'(2)) r_state <= S_TOPW;
                    else if (w_bin && r_depth >= DW'(2)) r_state <= S_MUL;
                    else r_state <= S_TOPRD;
                    case (r_cmd.cmd)
                        CMD_PUSH, CMD_PUSHLAST: if (r_depth < DMAX) r_depth <= r_depth + 1'b1;
                            else r_st <= ST_OVER;
                        CMD_DUP: if (r_depth == 0) r_st <= ST_UNDER;
                            else if (r_depth < DMAX) r_depth <= r_depth + 1'b1;
                            else r_st <= ST_OVER;
                        CMD_PUSHVAR: if (w_var_bad) r_st <= ST_UNDER;
                            else if (r_depth < DMAX) r_depth <= r_depth + 1'b1;
                            else r_st <= ST_OVER;
                        CMD_SWAP: if (r_depth < DW'(2)) r_st <= ST_UNDER;
                        CMD_CLEAR: r_depth <= '0;
                        CMD_PEEK: if (r_depth == 0) r_st <= ST_UNDER;
                        CMD_SETVAR: if (w_var_bad) r_st <= ST_UNDER;
                        CMD_COPYVAR: if (w_var_bad || w_src_bad) r_st <= ST_UNDER;
                        CMD_NEXTSTACK: begin
                            r_last <= (r_depth == 0) ? 32'd0 : r_b;
                            r_depth <= '0;
                        end
                        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD: begin
                            if (r_depth < DW'(2)) r_st <= ST_UNDER;
                        end
                        default: ;
                    endcase
                end
                S_MUL: begin
                    // operands now in r_a / r_b
                    r_prod <= w_prod;
                    r_neg  <= (r_cmd.cmd == CMD_DIV) ? (r_a[31] ^ r_b[31]) : r_a[31];
                    if (r_cmd.cmd == CMD_DIV || r_cmd.cmd == CMD_MOD) r_state <= S_DIVW;
                    else r_state <= S_FIN;
                end
                S_DIVW: begin
                    if (r_cmd.cmd == CMD_DIV ? (r_b == 0) : (w_ib == 0)) begin
                        r_st <= ST_DIVZ;
                        r_state <= S_FIN;
                    end else if (w_drsp.done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (r_st != ST_DIVZ) begin
                        r_depth <= w_dm1;
                        if (w_sflag) r_st <= ST_SAT;
                    end
                    r_state <= S_TOPRD;
                end
                S_TOPW: r_state <= S_TOPRD;
                S_TOPRD: r_state <= S_OUT;
                S_OUT: begin
                    r_out.top_value <= (r_depth == 0) ? 32'sd0 : s_rdata;
                    r_out.depth     <= 7'(r_depth);
                    r_out.status    <= r_st;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_out   = r_out;

`include "rpn_stack_calculator_unit_assert.svh"
    `RPN_ASSERT_IMPL(a_depth_max, i_clk, i_rst_n, r_depth <= DMAX)
    `RPN_ASSERT_NEXT(a_strobe_idle, i_clk, i_rst_n, r_state == S_OUT, o_valid && !o_busy)
    `RPN_ASSERT_NEXT(a_take_busy, i_clk, i_rst_n, i_start && !o_busy && r_state == S_IDLE, o_busy)
endmodule
